@@ sv/stbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sorted-table binary search core.
// No dependencies; imported by every module of the block.
package stbs_pkg;

  localparam int KEY_CHARS = 11;
  localparam int KEY_W     = 4 * KEY_CHARS;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int POS_W     = 10;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] entry_index;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_entry;
    logic load_bounds;
    logic probe;
    logic step;
    logic set_hit;
    logic set_miss;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic hit;
  } sts_t;

endpackage

@@ sv/stbs_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: issues table writes, bound loads and probe and compare steps to the datapath.
// Depends on stbs_pkg.
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (kind == KIND_SEARCH)) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_next = sts.empty ? ST_REPORT : ST_CMP;
      end
      ST_CMP: begin
        state_next = sts.hit ? ST_REPORT : ST_PROBE;
      end
      ST_REPORT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy            = 1'b0;
        cmd.write_entry = start && (kind == KIND_LOAD);
        cmd.load_bounds = start && (kind == KIND_SEARCH);
      end
      ST_PROBE: begin
        cmd.set_miss = sts.empty;
        cmd.probe    = !sts.empty;
      end
      ST_CMP: begin
        cmd.set_hit = sts.hit;
        cmd.step    = !sts.hit;
      end
      ST_REPORT: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/stbs_dp.sv @@
`timescale 1ns / 1ps
// Datapath: key table memory, search bounds, probe compare and result register.
// Depends on stbs_pkg; driven by stbs_ctrl commands.
module stbs_dp
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output rsp_t             rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] entry_count;
  logic [NW-1:0]    lo;
  logic [NW-1:0]    hi1;   // exclusive upper bound
  logic [AW-1:0]    mid_q;
  logic [NW-1:0]    span;
  logic [AW-1:0]    mid;
  logic [NW-1:0]    n_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  // Clamp count to the table depth.
  assign n_clamp = (32'(entry_count) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(entry_count);

  // Midpoint of the inclusive range lo .. hi1-1; only used while lo < hi1.
  assign span = hi1 - NW'(1) - lo;
  assign mid  = AW'(lo + (span >> 1));

  assign sts.empty = !(lo < hi1);
  assign sts.hit   = (rdata == key_q);

  always_ff @(posedge clk) begin
    if (cmd.write_entry && (32'(req.entry_index) < TABLE_DEPTH)) begin
      mem[AW'(req.entry_index)] <= req.key;
    end
    if (cmd.probe) begin
      rdata <= mem[mid];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bounds) begin
      lo    <= '0;
      hi1   <= n_clamp;
      key_q <= req.key;
    end
    if (cmd.probe) begin
      mid_q <= mid;
    end
    if (cmd.step) begin
      if (rdata < key_q) begin
        lo <= NW'(mid_q) + NW'(1);
      end else begin
        hi1 <= NW'(mid_q);
      end
    end
    if (cmd.set_hit) begin
      rsp.found    <= 1'b1;
      rsp.position <= POS_W'(mid_q);
    end else if (cmd.set_miss) begin
      rsp.found    <= 1'b0;
      rsp.position <= '0;
    end
  end

endmodule

@@ sv/sorted_table_binary_search_core.sv @@
`timescale 1ns / 1ps
// Top level of the sorted-table binary search core.
// Depends on stbs_pkg, stbs_ctrl and stbs_dp.
//
// Usage:
//   Request channel: drive req and raise start; the request is taken at a
//   rising edge where start is high and busy is low. A load request
//   (kind = 0) writes req.key into entry req.entry_index and
//   gives no result; indexes at or beyond TABLE_DEPTH are dropped. A search
//   request (kind = 1) runs a midpoint binary search over the first
//   entry_count entries (clamped to TABLE_DEPTH).
//   Result channel: done pulses for one cycle with rsp valid. The receiver
//   cannot stall; it must take the result in that cycle.
//   Config: cfg_we writes cfg_data into entry_count; write only while idle.
//   Search steps: each probe passes through ST_PROBE (registered table
//   read), then ST_CMP (compare). A hit leaves from ST_CMP and a miss from
//   ST_PROBE to ST_REPORT, where done pulses. A search makes at most
//   ceil(log2(n+1)) probes, n being the clamped entry_count. busy stays
//   high until done has pulsed.
//   Reset: rst clears the sequencer and entry_count to 0; table contents
//   are undefined until loaded and need no clearing pass.
module sorted_table_binary_search_core
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             done,
  output rsp_t             rsp
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the handshake and the probe/compare loop.
  stbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (req.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: key table, bounds, compare and held result.
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (rsp)
  );

endmodule

@@ sv/stbs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the binary search core, bound to the top level.
// Depends on stbs_pkg and sorted_table_binary_search_core.
module stbs_checker
  import stbs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input rsp_t rsp
);

  // A result only appears while a search is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // Release the request side right after the result.
  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after done");

  // A result never follows an idle cycle directly.
  a_no_instant: assert property (@(posedge clk) disable iff (rst) !busy |=> !done)
    else $error("done one cycle after idle");

  // A miss reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.found) |-> (rsp.position == '0))
    else $error("miss with nonzero position");

  // A load completes without occupying the core.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.kind == KIND_LOAD)) |=> !busy)
    else $error("load made the core busy");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_binary_search_core: drives loads and lookups,
// predicts every lookup result and compares it at the done strobe. Depends on stbs_pkg.
module tb;
  import stbs_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int FILL         = 256;     // entries loaded as a sorted prefix
  localparam int PHASE_ITEMS  = 25;
  localparam int SETTLE       = 30;      // covers the longest search, with margin
  localparam int LIMIT_CYCLES = 500000;
  localparam int REPORT_MAX   = 10;
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  req_t             req;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;
  logic             done;
  rsp_t             rsp;

  // Shadow copy of the key store and the entry_count register.
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic             shadow_valid [DEPTH];
  int               shadow_count;

  // Predicted lookup results, oldest first.
  rsp_t             expected_lookups [$];

  int mismatches;
  int n_loads;
  int n_lookups;
  int n_hits_seen;
  int n_count_writes;
  int cycle_count;

  sorted_table_binary_search_core #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .done    (done),
    .rsp     (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Midpoint binary search over the shadow store, clamped to the store depth.
  // Stop at the first probe that matches; report position 0 on a miss.
  function automatic rsp_t predict_lookup(logic [KEY_W-1:0] k);
    int   n;
    int   lo;
    int   hi;
    int   mid;
    rsp_t r;
    n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    lo = 0;
    hi = n - 1;
    r = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] == k) begin
        r.found    = 1'b1;
        r.position = POS_W'(mid);
        return r;
      end
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  // Walk the same probe sequence and return the first entry it would read
  // that was never loaded, or -1 when every probe hits a loaded entry.
  function automatic int first_unwritten_probe(logic [KEY_W-1:0] k);
    int n;
    int lo;
    int hi;
    int mid;
    n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (!shadow_valid[mid]) return mid;
      if (shadow_keys[mid] == k) return -1;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  // Well-formed digit string: 0..11 digit codes, zero fill after the end.
  function automatic logic [KEY_W-1:0] rand_digit_key();
    int               len;
    logic [KEY_W-1:0] k;
    len = $urandom_range(0, KEY_CHARS);
    k = '0;
    for (int i = 0; i < len; i++) k[KEY_W-1-4*i -: 4] = 4'($urandom_range(1, 10));
    return k;
  endfunction

  // Any bit pattern: odd nibble codes and digits after an end mark included.
  function automatic logic [KEY_W-1:0] rand_raw_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  // Key that keeps the store in ascending order when written at idx.
  function automatic logic [KEY_W-1:0] ordered_key_for(int idx);
    logic [63:0] lo_k;
    logic [63:0] hi_k;
    logic [63:0] span;
    lo_k = (idx > 0) ? 64'(shadow_keys[idx-1]) : 64'd0;
    hi_k = (idx < DEPTH - 1) ? 64'(shadow_keys[idx+1]) : 64'(KEY_ALL_ONES);
    if (hi_k < lo_k) return lo_k[KEY_W-1:0];
    span = hi_k - lo_k + 64'd1;
    return KEY_W'(lo_k + ({$urandom, $urandom} % span));
  endfunction

  // Present one request at the falling edge and hold it until it is taken.
  // Leave start high on return; the next request or an idle cycle replaces it.
  task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx,
                              input logic [KEY_W-1:0] k);
    req_t r;
    r.kind        = kind;
    r.entry_index = idx;
    r.key         = k;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: update the shadow or queue the predicted result.
    if (kind == KIND_SEARCH) begin
      expected_lookups.push_back(predict_lookup(k));
      n_lookups++;
    end else begin
      shadow_keys[idx]  = k;
      shadow_valid[idx] = 1'b1;
      n_loads++;
    end
  endtask

  task automatic load_entry(input int idx, input logic [KEY_W-1:0] k);
    send_request(KIND_LOAD, IDX_W'(idx), k);
  endtask

  // Searches carry a random entry_index, which the block must ignore.
  task automatic lookup(input logic [KEY_W-1:0] k);
    send_request(KIND_SEARCH, IDX_W'($urandom_range(0, DEPTH - 1)), k);
  endtask

  // Load whatever entries the search for k would read unloaded, then search.
  task automatic checked_lookup(input logic [KEY_W-1:0] k);
    int gap;
    gap = first_unwritten_probe(k);
    while (gap >= 0) begin
      load_entry(gap, ordered_key_for(gap));
      gap = first_unwritten_probe(k);
    end
    lookup(k);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start, wait for every predicted result, then let the block settle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write entry_count only while the block is quiet.
  task automatic write_count(input int value);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CNT_W'(value);
    @(negedge clk);
    cfg_we   <= 1'b0;
    shadow_count = value;
    n_count_writes++;
  endtask

  // Count zero right after reset, then a three-entry store; no unwritten
  // entry is ever inside the searched range.
  task automatic test_empty_and_tiny();
    lookup('0);
    lookup(KEY_ALL_ONES);
    lookup(rand_digit_key());
    load_entry(0, 44'h100_0000_0000);
    load_entry(1, 44'h210_0000_0000);
    load_entry(2, 44'h2A1_0000_0000);
    write_count(3);
    lookup(44'h210_0000_0000);
    lookup(44'h2A1_0000_0000);
    lookup(44'h200_0000_0000);
  endtask

  // Build an ascending key set: zero first, all ones last, and a run of equal
  // keys so the duplicate rule is exercised. Load the sorted prefix, then the
  // entries probed by a full-depth search that always moves right, so keys
  // at both ends of the full store can be searched.
  task automatic fill_sorted_store();
    logic [KEY_W-1:0] keys [DEPTH];
    logic [KEY_W-1:0] t;
    int               j;
    int               lo;
    int               hi;
    int               mid;
    for (int i = 0; i < DEPTH; i++) keys[i] = rand_digit_key();
    for (int i = 1; i < DEPTH; i++) begin
      t = keys[i];
      j = i - 1;
      while (j >= 0 && keys[j] > t) begin
        keys[j+1] = keys[j];
        j--;
      end
      keys[j+1] = t;
    end
    keys[0]       = '0;
    keys[DEPTH-1] = KEY_ALL_ONES;
    for (int i = 101; i <= 110; i++) keys[i] = keys[100];
    for (int i = 0; i < FILL; i++) begin
      load_entry(i, keys[i]);
      if ($urandom_range(0, 15) == 0) idle_cycles($urandom_range(1, 11));
    end
    lo = 0;
    hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mid >= FILL) load_entry(mid, keys[mid]);
      lo = mid + 1;
    end
  endtask

  // Extremes of entry_count on the loaded store.
  task automatic test_count_extremes();
    write_count(DEPTH);
    checked_lookup('0);
    checked_lookup(KEY_ALL_ONES);
    checked_lookup(shadow_keys[511]);
    checked_lookup(shadow_keys[100] + 1'b1);
    checked_lookup(shadow_keys[105]);
    write_count(2047);
    checked_lookup(KEY_ALL_ONES);
    checked_lookup(shadow_keys[767]);
    write_count(1);
    checked_lookup('0);
    checked_lookup(KEY_ALL_ONES);
    write_count(DEPTH - 1);
    checked_lookup(KEY_ALL_ONES);
    checked_lookup(shadow_keys[DEPTH-2]);
  endtask

  // Break the order at a few entries and search through the broken spots.
  task automatic test_unsorted_store();
    load_entry(5, KEY_ALL_ONES);
    load_entry(1000, '0);
    write_count(DEPTH);
    checked_lookup(KEY_ALL_ONES);
    checked_lookup('0);
    checked_lookup(shadow_keys[6]);
  endtask

  // One random request: mostly hits on stored keys and near misses, with
  // order-keeping loads, plus some noise loads and raw keys. A search that
  // would read an unloaded entry loads that entry instead.
  task automatic random_request();
    int               sel;
    int               n;
    int               idx;
    int               gap;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    n   = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    idx = $urandom_range(0, DEPTH - 1);
    if (sel < 15) load_entry(idx, ordered_key_for(idx));
    else if (sel < 18) load_entry(idx, rand_raw_key());
    else begin
      if (sel < 60) k = shadow_keys[(n > 0) ? $urandom_range(0, n - 1) : idx];
      else if (sel < 75) begin
        if ($urandom_range(0, 1) == 1) k = shadow_keys[idx] + 1'b1;
        else k = shadow_keys[idx] - 1'b1;
      end else if (sel < 90) k = rand_digit_key();
      else k = rand_raw_key();
      gap = first_unwritten_probe(k);
      if (gap >= 0) load_entry(gap, ordered_key_for(gap));
      else lookup(k);
    end
  endtask

  // Ten phases, each with its own entry_count; the last two run back to back.
  task automatic test_random_traffic();
    int counts [10];
    counts[0] = DEPTH;
    counts[1] = 2047;
    counts[2] = 1;
    counts[3] = 2;
    counts[4] = $urandom_range(3, FILL);
    counts[5] = 0;
    counts[6] = DEPTH - 1;
    counts[7] = $urandom_range(DEPTH + 1, 2046);
    counts[8] = $urandom_range(1, FILL);
    counts[9] = DEPTH;
    for (int p = 0; p < 10; p++) begin
      write_count(counts[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_request();
        if (p < 8 && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 11));
      end
    end
  endtask

  // Compare every strobed result against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result with nothing pending: found=%0b position=%0d",
                   $time, rsp.found, rsp.position);
      end else begin
        want = expected_lookups.pop_front();
        if (rsp.found) n_hits_seen++;
        if (rsp.found !== want.found || rsp.position !== want.position) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] lookup: expected found=%0b position=%0d, got found=%0b position=%0d",
                     $time, want.found, want.position, rsp.found, rsp.position);
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_lookups.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    req      = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    shadow_count   = 0;
    mismatches     = 0;
    n_loads        = 0;
    n_lookups      = 0;
    n_hits_seen    = 0;
    n_count_writes = 0;
    cycle_count    = 0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_keys[i]  = '0;
      shadow_valid[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_tiny();
    fill_sorted_store();
    test_count_extremes();
    test_unsorted_store();
    test_random_traffic();
    drain();

    $display("Ran %0d loads and %0d lookups (%0d hits) across %0d entry_count settings,",
             n_loads, n_lookups, n_hits_seen, n_count_writes);
    $display("including empty, one-entry, full and over-range counts; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
